FILE: design/csw_pkg.sv
package csw_pkg;

    // kinds of work handed from the line parser to the wave engine
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_BYTE,
        KIND_UNKNOWN,
        KIND_UP,
        KIND_DOWN,
        KIND_PRESET
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [11:0] preset_freq;
    } queue_entry_t;

    typedef struct packed {
        logic [23:0] numerator;
        logic [9:0]  step_size;
        logic [11:0] upper_limit;
        logic [11:0] lower_limit;
    } cfg_t;

    typedef enum logic [0:0] {
        BACK_RUN,
        BACK_DIV
    } back_state_t;

    // configuration register indexes
    localparam logic [1:0] CFG_NUMERATOR = 2'd0;
    localparam logic [1:0] CFG_STEP      = 2'd1;
    localparam logic [1:0] CFG_UPPER     = 2'd2;
    localparam logic [1:0] CFG_LOWER     = 2'd3;

    // reply codes
    localparam logic [2:0] REPLY_NONE    = 3'd0;
    localparam logic [2:0] REPLY_PRESET  = 3'd1;
    localparam logic [2:0] REPLY_UP      = 3'd2;
    localparam logic [2:0] REPLY_DOWN    = 3'd3;
    localparam logic [2:0] REPLY_RANGE   = 3'd4;
    localparam logic [2:0] REPLY_UNKNOWN = 3'd5;

    // reset values
    localparam logic [23:0] NUMERATOR_RST = 24'd460800;
    localparam logic [9:0]  STEP_RST      = 10'd100;
    localparam logic [11:0] UPPER_RST     = 12'd2000;
    localparam logic [11:0] LOWER_RST     = 12'd500;
    localparam logic [11:0] FREQ_RST      = 12'd1000;
    localparam logic [15:0] RELOAD_RST    = 16'd65076;

    // preset frequencies
    localparam logic [11:0] PRESET_C = 12'd1000;
    localparam logic [11:0] PRESET_D = 12'd2000;
    localparam logic [11:0] PRESET_E = 12'd2400;
    localparam logic [11:0] PRESET_F = 12'd400;
    localparam logic [11:0] PRESET_G = 12'd300;

    // characters
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_B   = 8'h42;
    localparam logic [7:0] CHAR_C   = 8'h43;
    localparam logic [7:0] CHAR_D   = 8'h44;
    localparam logic [7:0] CHAR_E   = 8'h45;
    localparam logic [7:0] CHAR_F   = 8'h46;
    localparam logic [7:0] CHAR_G   = 8'h47;

    localparam int unsigned DIV_STEPS = 24;

endpackage

FILE: design/csw_front.sv
module csw_front
    import csw_pkg::*;
#(
    parameter int unsigned LINE_WRAP = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  logic         opcode,
    input  logic [7:0]   rx_byte,
    input  logic         q_full,
    output logic         q_push,
    output queue_entry_t q_entry
);

    localparam int unsigned POS_W = $clog2(LINE_WRAP + 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       first_reg;
    logic [7:0]       first_next;
    logic [7:0]       second_reg;
    logic [7:0]       second_next;

    logic [POS_W-1:0] pos_eff;
    logic [7:0]       c0;
    logic [7:0]       c1;

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    // a full line wraps back to the start before the next byte lands
    assign pos_eff = (pos_reg >= POS_W'(LINE_WRAP)) ? '0 : pos_reg;

    always_comb
    begin
        c0 = first_reg;
        c1 = (pos_eff >= POS_W'(2)) ? second_reg : CHAR_NUL;
        // one trailing cr before the lf is dropped
        if (pos_eff == POS_W'(1) && c0 == CHAR_CR)
        begin
            c0 = CHAR_NUL;
        end
        if (pos_eff == POS_W'(2) && c1 == CHAR_CR)
        begin
            c1 = CHAR_NUL;
        end
    end

    always_comb
    begin
        q_entry.kind        = KIND_TICK;
        q_entry.preset_freq = '0;
        pos_next    = pos_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (opcode)
        begin
            q_entry.kind = KIND_BYTE;
            if (rx_byte == CHAR_LF)
            begin
                pos_next = '0;
                if (pos_eff == '0 || c1 != CHAR_NUL)
                begin
                    q_entry.kind = KIND_UNKNOWN;
                end
                else
                begin
                    case (c0)
                        CHAR_A: q_entry.kind = KIND_UP;
                        CHAR_B: q_entry.kind = KIND_DOWN;
                        CHAR_C:
                        begin
                            q_entry.kind        = KIND_PRESET;
                            q_entry.preset_freq = PRESET_C;
                        end
                        CHAR_D:
                        begin
                            q_entry.kind        = KIND_PRESET;
                            q_entry.preset_freq = PRESET_D;
                        end
                        CHAR_E:
                        begin
                            q_entry.kind        = KIND_PRESET;
                            q_entry.preset_freq = PRESET_E;
                        end
                        CHAR_F:
                        begin
                            q_entry.kind        = KIND_PRESET;
                            q_entry.preset_freq = PRESET_F;
                        end
                        CHAR_G:
                        begin
                            q_entry.kind        = KIND_PRESET;
                            q_entry.preset_freq = PRESET_G;
                        end
                        default: q_entry.kind = KIND_UNKNOWN;
                    endcase
                end
            end
            else
            begin
                if (pos_eff == '0)
                begin
                    first_next = rx_byte;
                end
                else if (pos_eff == POS_W'(1))
                begin
                    second_next = rx_byte;
                end
                pos_next = pos_eff + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            first_reg  <= CHAR_NUL;
            second_reg <= CHAR_NUL;
        end
        else if (q_push)
        begin
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

FILE: design/csw_queue.sv
module csw_queue
    import csw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t push_entry,
    input  logic         pop,
    output logic         full,
    output logic         head_valid,
    output queue_entry_t head
);

    queue_entry_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: design/csw_div.sv
module csw_div
    import csw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [11:0] divisor,
    output logic        done,
    output logic [23:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [11:0] rem_reg;
    logic [11:0] rem_next;
    logic [23:0] work_reg;
    logic [11:0] dsr_reg;
    logic [12:0] trial;
    logic        ge;

    // restoring shift-subtract, one quotient bit per cycle
    assign trial    = {rem_reg, work_reg[23]};
    assign ge       = (trial >= {1'b0, dsr_reg});
    assign rem_next = ge ? 12'(trial - {1'b0, dsr_reg}) : trial[11:0];

    assign done     = done_reg;
    assign quotient = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            work_reg <= dividend;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            work_reg <= {work_reg[22:0], ge};
        end
    end

endmodule

FILE: design/csw_back.sv
module csw_back
    import csw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         q_valid,
    input  queue_entry_t q_head,
    output logic         q_pop,
    output logic         result_valid,
    input  logic         result_stall,
    output logic         wave_level,
    output logic [2:0]   reply_code,
    output logic [11:0]  frequency_now,
    output logic [15:0]  reload_now
);

    back_state_t state_reg;
    back_state_t state_next;

    logic        wave_reg;
    logic        wave_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] reload_reg;
    logic [15:0] reload_next;
    logic [11:0] freq_reg;
    logic [11:0] freq_next;
    logic [2:0]  pend_reg;
    logic [2:0]  pend_next;

    logic        out_valid_reg;
    logic        out_wave_reg;
    logic [2:0]  out_reply_reg;
    logic [11:0] out_freq_reg;
    logic [15:0] out_reload_reg;

    logic        slot_free;
    logic        out_load;
    logic [2:0]  out_reply;
    logic        apply;
    logic [11:0] apply_freq;
    logic [2:0]  apply_reply;
    logic        div_start;
    logic        div_done;
    logic [23:0] div_quot;

    logic [12:0] sum_up;
    logic        up_ok;
    logic [12:0] down_floor;
    logic        down_ok;

    assign slot_free = !out_valid_reg || !result_stall;

    assign sum_up     = {1'b0, freq_reg} + {3'b0, cfg.step_size};
    assign up_ok      = (sum_up <= {1'b0, cfg.upper_limit});
    assign down_floor = {3'b0, cfg.step_size} + {1'b0, cfg.lower_limit};
    assign down_ok    = ({1'b0, freq_reg} >= down_floor) && (freq_reg > {2'b0, cfg.step_size});

    csw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg.numerator),
        .divisor  (apply_freq),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_RUN:
            begin
                if (div_start)
                begin
                    state_next = BACK_DIV;
                end
            end
            BACK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BACK_RUN;
                end
            end
            default: state_next = BACK_RUN;
        endcase
    end

    always_comb
    begin
        wave_next   = wave_reg;
        count_next  = count_reg;
        reload_next = reload_reg;
        freq_next   = freq_reg;
        pend_next   = pend_reg;
        out_load    = 1'b0;
        out_reply   = REPLY_NONE;
        apply       = 1'b0;
        apply_freq  = q_head.preset_freq;
        apply_reply = REPLY_PRESET;
        div_start   = 1'b0;
        q_pop       = 1'b0;
        case (state_reg)
            BACK_RUN:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        KIND_TICK:
                        begin
                            out_load   = 1'b1;
                            count_next = count_reg + 16'd1;
                            // overflow reloads and flips the wave
                            if (count_reg == 16'hFFFF)
                            begin
                                count_next = reload_reg;
                                wave_next  = ~wave_reg;
                            end
                        end
                        KIND_BYTE:
                        begin
                            out_load = 1'b1;
                        end
                        KIND_UP:
                        begin
                            if (up_ok)
                            begin
                                apply       = 1'b1;
                                apply_freq  = sum_up[11:0];
                                apply_reply = REPLY_UP;
                            end
                            else
                            begin
                                out_load  = 1'b1;
                                out_reply = REPLY_RANGE;
                            end
                        end
                        KIND_DOWN:
                        begin
                            if (down_ok)
                            begin
                                apply       = 1'b1;
                                apply_freq  = freq_reg - {2'b0, cfg.step_size};
                                apply_reply = REPLY_DOWN;
                            end
                            else
                            begin
                                out_load  = 1'b1;
                                out_reply = REPLY_RANGE;
                            end
                        end
                        KIND_PRESET:
                        begin
                            apply       = 1'b1;
                            apply_reply = REPLY_PRESET;
                        end
                        default:
                        begin
                            out_load  = 1'b1;
                            out_reply = REPLY_UNKNOWN;
                        end
                    endcase
                    if (apply)
                    begin
                        freq_next = apply_freq;
                        pend_next = apply_reply;
                        if (apply_freq == '0)
                        begin
                            reload_next = '0;
                            out_load    = 1'b1;
                            out_reply   = apply_reply;
                        end
                        else
                        begin
                            div_start = 1'b1;
                        end
                    end
                end
            end
            BACK_DIV:
            begin
                if (div_done)
                begin
                    out_load  = 1'b1;
                    out_reply = pend_reg;
                    // reload saturates at 0 and at 65535
                    if (div_quot[23:16] != '0)
                    begin
                        reload_next = '0;
                    end
                    else if (div_quot[15:0] == '0)
                    begin
                        reload_next = 16'hFFFF;
                    end
                    else
                    begin
                        reload_next = 16'(17'h10000 - {1'b0, div_quot[15:0]});
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_RUN;
            wave_reg      <= 1'b1;
            count_reg     <= '0;
            reload_reg    <= RELOAD_RST;
            freq_reg      <= FREQ_RST;
            pend_reg      <= REPLY_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wave_reg   <= wave_next;
            count_reg  <= count_next;
            reload_reg <= reload_next;
            freq_reg   <= freq_next;
            pend_reg   <= pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_wave_reg   <= wave_next;
            out_reply_reg  <= out_reply;
            out_freq_reg   <= freq_next;
            out_reload_reg <= reload_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign wave_level    = out_wave_reg;
    assign reply_code    = out_reply_reg;
    assign frequency_now = out_freq_reg;
    assign reload_now    = out_reload_reg;

endmodule

FILE: design/command_tuned_square_wave.sv
// path: a beat that sets no new frequency is held in a queue entry, then in the output
// register, which result_stall can hold; a line that sets a new frequency also waits
// for the restoring shift-subtract divider before reaching the output register
// throughput: one tick or byte per cycle when neither stall holds; a frequency-changing
// line holds the back end for the division while the two-entry queue takes up to two
// more beats; reset: rst_n clears the state registers at once, no clearing pass
module command_tuned_square_wave
    import csw_pkg::*;
#(
    parameter int unsigned LINE_WRAP = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        wave_level,
    output logic [2:0]  reply_code,
    output logic [11:0] frequency_now,
    output logic [15:0] reload_now
);

    cfg_t         cfg_reg;
    logic         q_full;
    logic         q_push;
    logic         q_pop;
    logic         q_valid;
    queue_entry_t q_entry;
    queue_entry_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.numerator   <= NUMERATOR_RST;
            cfg_reg.step_size   <= STEP_RST;
            cfg_reg.upper_limit <= UPPER_RST;
            cfg_reg.lower_limit <= LOWER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUMERATOR: cfg_reg.numerator   <= cfg_data;
                CFG_STEP:      cfg_reg.step_size   <= cfg_data[9:0];
                CFG_UPPER:     cfg_reg.upper_limit <= cfg_data[11:0];
                CFG_LOWER:     cfg_reg.lower_limit <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    csw_front #(
        .LINE_WRAP (LINE_WRAP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .opcode     (opcode),
        .rx_byte    (rx_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    csw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    csw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .wave_level    (wave_level),
        .reply_code    (reply_code),
        .frequency_now (frequency_now),
        .reload_now    (reload_now)
    );

    // a step up never lands above the upper limit
    a_up_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && reply_code == REPLY_UP |-> frequency_now <= cfg_reg.upper_limit)
        else $error("step up beyond upper limit");

    // a step down never lands below the lower limit or at zero
    a_down_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && reply_code == REPLY_DOWN
        |-> frequency_now >= cfg_reg.lower_limit && frequency_now != '0)
        else $error("step down below lower limit");

    // a preset reply carries one of the preset frequencies
    a_preset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && reply_code == REPLY_PRESET
        |-> frequency_now == PRESET_C || frequency_now == PRESET_D
            || frequency_now == PRESET_E || frequency_now == PRESET_F
            || frequency_now == PRESET_G)
        else $error("preset reply with odd frequency");

    // nothing is popped from an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
